[sv/fdnd_pkg.sv]
// Shared types and constants for the FAT directory entry name decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fdnd_pkg;

    typedef enum logic [2:0] {
        CLS_LISTED   = 3'd0,
        CLS_END      = 3'd1,
        CLS_DELETED  = 3'd2,
        CLS_LONGNAME = 3'd3,
        CLS_DOT      = 3'd4,
        CLS_AFTER    = 3'd5
    } entry_class_t;

    localparam logic [7:0] BYTE_END       = 8'h00;
    localparam logic [7:0] BYTE_DELETED   = 8'hE5;
    localparam logic [7:0] BYTE_KANJI_DEL = 8'h05;
    localparam logic [7:0] BYTE_DOT_ENTRY = 8'h2E;
    localparam logic [7:0] ATTR_RO        = 8'h01;
    localparam logic [7:0] ATTR_HID       = 8'h02;
    localparam logic [7:0] ATTR_SYS       = 8'h04;
    localparam logic [7:0] ATTR_VOL       = 8'h08;
    localparam logic [7:0] ATTR_DIRECTORY = 8'h10;
    localparam logic [7:0] ATTR_LONG      = ATTR_RO | ATTR_HID | ATTR_SYS | ATTR_VOL;
    localparam logic [7:0] CH_SPACE       = 8'h20;
    localparam logic [7:0] CH_DOT         = 8'h2E;

    localparam int NAME_BYTES  = 8;
    localparam int TEXT_BYTES  = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified entry handed from front to back
    typedef struct packed {
        entry_class_t cls;
        logic         is_dir;
        logic [63:0]  name;
        logic [23:0]  ext;
        logic [3:0]   lead;      // leading spaces, 0..8
        logic [3:0]   base_len;  // trimmed name length, 0..8
    } fdnd_entry_t;

endpackage

`default_nettype wire

[sv/fat_dir_entry_name_decoder.sv]
// Top level of the FAT directory entry 8.3 name decoder.
// Depends on fdnd_pkg, fdnd_front, fdnd_queue and fdnd_back.
`timescale 1ns / 1ps
`default_nettype none

// Decodes one FAT directory entry (8 name bytes, 3 extension bytes,
// attribute byte) per transfer into a class and, for listed entries, the
// trimmed "NAME.EXT" display text with its length and the directory bit.
// One entry is accepted every clock cycle when results are popped as fast;
// a result is registered in the queue and then in the output register.
// The rate is set by the two-entry queue between classifier and name
// builder plus the output register: up to three results can be held while
// pop is low, after which full rises. Asserting new_sector with an entry
// clears the end-of-sector state before that entry is classified.
module fat_dir_entry_name_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        new_sector,
    input  wire logic [63:0] name_chars,
    input  wire logic [23:0] ext_chars,
    input  wire logic [7:0]  attributes,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       entry_class,
    output logic             is_directory,
    output logic [63:0]      text_low,
    output logic [31:0]      text_high,
    output logic [3:0]       text_length
);
    import fdnd_pkg::*;

    fdnd_entry_t wr_entry;
    fdnd_entry_t rd_entry;
    logic        q_wr;
    logic        q_rd;
    logic        q_full;
    logic        q_empty;

    assign full = q_full;

    fdnd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .new_sector (new_sector),
        .name_chars (name_chars),
        .ext_chars  (ext_chars),
        .attributes (attributes),
        .q_full     (q_full),
        .q_wr       (q_wr),
        .q_data     (wr_entry)
    );

    fdnd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (wr_entry),
        .rd      (q_rd),
        .rd_data (rd_entry),
        .full    (q_full),
        .empty   (q_empty)
    );

    fdnd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (rd_entry),
        .q_rd         (q_rd),
        .pop          (pop),
        .empty        (empty),
        .entry_class  (entry_class),
        .is_directory (is_directory),
        .text_low     (text_low),
        .text_high    (text_high),
        .text_length  (text_length)
    );

endmodule

`default_nettype wire

[sv/fdnd_front.sv]
// Front end: accepts entries, tracks end-of-sector state, classifies and
// measures the space trim. Depends on fdnd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdnd_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic                 new_sector,
    input  wire logic [63:0]          name_chars,
    input  wire logic [23:0]          ext_chars,
    input  wire logic [7:0]           attributes,
    input  wire logic                 q_full,
    output logic                      q_wr,
    output fdnd_pkg::fdnd_entry_t     q_data
);
    import fdnd_pkg::*;

    logic       end_seen_reg;
    logic       end_seen_next;
    logic       end_eff;
    logic [7:0] b0;
    logic [3:0] lead;
    logic [3:0] trail;
    logic       lead_done;
    logic       trail_done;

    assign q_wr    = push && !q_full;
    assign b0      = name_chars[7:0];
    assign end_eff = end_seen_reg && !new_sector;

    always_comb
    begin
        lead       = 4'd0;
        trail      = 4'd0;
        lead_done  = 1'b0;
        trail_done = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            if (!lead_done && name_chars[i*8 +: 8] == CH_SPACE)
                lead = lead + 4'd1;
            else
                lead_done = 1'b1;
            if (!trail_done && name_chars[(NAME_BYTES-1-i)*8 +: 8] == CH_SPACE)
                trail = trail + 4'd1;
            else
                trail_done = 1'b1;
        end
    end

    always_comb
    begin
        q_data.name     = name_chars;
        q_data.ext      = ext_chars;
        q_data.lead     = lead;
        q_data.is_dir   = (attributes & ATTR_DIRECTORY) != 8'h00;
        // all spaces: lead and trail both count 8
        q_data.base_len = (lead == 4'(NAME_BYTES)) ? 4'd0 : 4'(NAME_BYTES) - lead - trail;
        if (end_eff)
            q_data.cls = CLS_AFTER;
        else if (b0 == BYTE_END)
            q_data.cls = CLS_END;
        else if (b0 == BYTE_DELETED || b0 == BYTE_KANJI_DEL)
            q_data.cls = CLS_DELETED;
        else if (attributes == ATTR_LONG)
            q_data.cls = CLS_LONGNAME;
        else if (b0 == BYTE_DOT_ENTRY)
            q_data.cls = CLS_DOT;
        else
            q_data.cls = CLS_LISTED;
    end

    assign end_seen_next = q_wr ? (end_eff || b0 == BYTE_END) : end_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            end_seen_reg <= 1'b0;
        else
            end_seen_reg <= end_seen_next;
    end

endmodule

`default_nettype wire

[sv/fdnd_queue.sv]
// Short queue between front and back so either side can stall alone.
// Depends on fdnd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdnd_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr,
    input  wire fdnd_pkg::fdnd_entry_t wr_data,
    input  wire logic                 rd,
    output fdnd_pkg::fdnd_entry_t     rd_data,
    output logic                      full,
    output logic                      empty
);
    import fdnd_pkg::*;

    fdnd_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr && !rd)
            count_next = count_reg + 1'b1;
        else if (rd && !wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(wr && full && !rd))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(rd && empty))
        else $error("queue read while empty");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[sv/fdnd_back.sv]
// Back end: builds the display name from a classified entry and holds it
// in the output register until popped. Depends on fdnd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdnd_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_empty,
    input  wire fdnd_pkg::fdnd_entry_t q_data,
    output logic                       q_rd,
    input  wire logic                  pop,
    output logic                       empty,
    output logic [2:0]                 entry_class,
    output logic                       is_directory,
    output logic [63:0]                text_low,
    output logic [31:0]                text_high,
    output logic [3:0]                 text_length
);
    import fdnd_pkg::*;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    entry_class_t              cls_reg;
    logic                      dir_reg;
    logic [TEXT_BYTES*8-1:0]   text_reg;
    logic [TEXT_BYTES*8-1:0]   text_next;
    logic [3:0]                len_reg;
    logic [3:0]                len_next;
    logic                      load;
    logic                      listed;
    logic                      has_ext;
    logic [63:0]               shifted;
    logic [31:0]               ext_seq;
    logic [3:0]                rel;

    assign load    = !q_empty && (!out_valid_reg || pop);
    assign q_rd    = load;
    assign listed  = q_data.cls == CLS_LISTED;
    assign has_ext = q_data.ext[7:0] != CH_SPACE;
    assign shifted = q_data.name >> {q_data.lead, 3'b000};
    assign ext_seq = {q_data.ext, CH_DOT};

    always_comb
    begin
        text_next = '0;
        rel       = 4'd0;
        for (int i = 0; i < TEXT_BYTES; i++)
        begin
            rel = 4'(i) - q_data.base_len;
            if (4'(i) < q_data.base_len)
            begin
                if (i < NAME_BYTES)
                    text_next[i*8 +: 8] = shifted[(i % NAME_BYTES)*8 +: 8];
            end
            else if (has_ext && rel < 4'd4)
                text_next[i*8 +: 8] = ext_seq[{rel[1:0], 3'b000} +: 8];
        end
        len_next = q_data.base_len + (has_ext ? 4'd4 : 4'd0);
        if (!listed)
        begin
            text_next = '0;
            len_next  = 4'd0;
        end
    end

    assign out_valid_next = load ? 1'b1 : (pop ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cls_reg  <= q_data.cls;
            dir_reg  <= listed && q_data.is_dir;
            text_reg <= text_next;
            len_reg  <= len_next;
        end
    end

    assign empty        = !out_valid_reg;
    assign entry_class  = cls_reg;
    assign is_directory = dir_reg;
    assign text_low     = text_reg[63:0];
    assign text_high    = text_reg[95:64];
    assign text_length  = len_reg;

    a_skip_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cls_reg != CLS_LISTED) |-> (len_reg == 4'd0 && !dir_reg))
        else $error("skipped entry carries a name");
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (len_reg <= 4'(TEXT_BYTES)))
        else $error("display length out of range");
    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |-> !q_rd)
        else $error("output register overwritten");

endmodule

`default_nettype wire

[sim/fat_dir_entry_name_decoder_tb.sv]
// Self-checking testbench for fat_dir_entry_name_decoder: directed entries, then random ones.
// Expected results come from a local entry classifier and are checked in order at the pop side.
// Depends on fdnd_pkg and the RTL of the block.
`timescale 1ns / 1ps

module fat_dir_entry_name_decoder_tb;
    import fdnd_pkg::*;

    localparam int RANDOM_ENTRIES = 1200;
    localparam int IDLE_PCT       = 34;
    localparam int HOLD_CYCLES    = 64;
    localparam int HOLD_AT        = 300;
    localparam int STEADY_FROM    = 500;
    localparam int STEADY_TO      = 700;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LIMIT_NS       = 2_000_000;

    typedef struct packed {
        logic        new_sector;
        logic [63:0] name;
        logic [23:0] ext;
        logic [7:0]  attr;
    } dir_entry_t;

    typedef struct packed {
        entry_class_t cls;
        logic         dir;
        logic [63:0]  lo;
        logic [31:0]  hi;
        logic [3:0]   len;
    } display_name_t;

    typedef struct packed {
        dir_entry_t   entry;
        logic         typed;     // expected class written in the row
        entry_class_t cls;
    } table_row_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic        new_sector   = 1'b0;
    logic [63:0] name_chars   = '0;
    logic [23:0] ext_chars    = '0;
    logic [7:0]  attributes   = '0;
    logic        empty;
    logic        pop          = 1'b0;
    logic [2:0]  entry_class;
    logic        is_directory;
    logic [63:0] text_low;
    logic [31:0] text_high;
    logic [3:0]  text_length;

    display_name_t expected_names [$];
    table_row_t    directed_rows [$];
    logic          sector_ended = 1'b0;
    int            errors       = 0;
    int            names_seen   = 0;

    fat_dir_entry_name_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .new_sector   (new_sector),
        .name_chars   (name_chars),
        .ext_chars    (ext_chars),
        .attributes   (attributes),
        .empty        (empty),
        .pop          (pop),
        .entry_class  (entry_class),
        .is_directory (is_directory),
        .text_low     (text_low),
        .text_high    (text_high),
        .text_length  (text_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #LIMIT_NS;
        $display("FAIL fat_dir_entry_name_decoder");
        $finish;
    end

    // Classifies one entry and builds its display name; tracks the end-of-sector state.
    function automatic display_name_t decode_entry(input dir_entry_t e);
        display_name_t r;
        logic [7:0]    txt [12];
        logic [7:0]    b0;
        int            first;
        int            last;
        int            len;
        int            i;
        r = '0;
        for (i = 0; i < 12; i++)
            txt[i] = 8'h00;
        b0 = e.name[7:0];
        if (e.new_sector)
            sector_ended = 1'b0;
        if (sector_ended)
        begin
            r.cls = CLS_AFTER;
            return r;
        end
        if (b0 == BYTE_END)
        begin
            sector_ended = 1'b1;
            r.cls = CLS_END;
            return r;
        end
        if (b0 == BYTE_DELETED || b0 == BYTE_KANJI_DEL)
        begin
            r.cls = CLS_DELETED;
            return r;
        end
        if (e.attr == ATTR_LONG)
        begin
            r.cls = CLS_LONGNAME;
            return r;
        end
        if (b0 == BYTE_DOT_ENTRY)
        begin
            r.cls = CLS_DOT;
            return r;
        end
        len = 0;
        first = 0;
        while (first < NAME_BYTES && e.name[8*first +: 8] == CH_SPACE)
            first++;
        if (first < NAME_BYTES)
        begin
            last = NAME_BYTES - 1;
            while (last > first && e.name[8*last +: 8] == CH_SPACE)
                last--;
            for (i = first; i <= last; i++)
            begin
                txt[len] = e.name[8*i +: 8];
                len++;
            end
        end
        if (e.ext[7:0] != CH_SPACE)
        begin
            txt[len] = CH_DOT;
            len++;
            for (i = 0; i < 3; i++)
            begin
                txt[len] = e.ext[8*i +: 8];
                len++;
            end
        end
        for (i = 0; i < len; i++)
        begin
            if (i < 8)
                r.lo[8*i +: 8] = txt[i];
            else
                r.hi[8*(i-8) +: 8] = txt[i];
        end
        r.cls = CLS_LISTED;
        r.dir = (e.attr & ATTR_DIRECTORY) != 8'h00;
        r.len = len[3:0];
        return r;
    endfunction

    // String literals put the first character on top; the block wants it in bits 7..0.
    function automatic logic [63:0] le8(input logic [63:0] s);
        logic [63:0] r;
        int          i;
        for (i = 0; i < 8; i++)
            r[8*i +: 8] = s[8*(7-i) +: 8];
        return r;
    endfunction

    function automatic logic [63:0] lead_byte(input logic [7:0] b, input logic [63:0] rest);
        return {rest[63:8], b};
    endfunction

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return CH_SPACE;
        else if (r < 55)
            return 8'($urandom_range(8'h21, 8'h7E));
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed listed entries, with markers, deletions and long names mixed in.
    function automatic dir_entry_t random_entry();
        dir_entry_t e;
        int         r;
        int         i;
        e.new_sector = $urandom_range(0, 99) < 20;
        for (i = 0; i < NAME_BYTES; i++)
            e.name[8*i +: 8] = rand_char();
        r = $urandom_range(0, 99);
        if (r < 3)
            e.name[7:0] = BYTE_END;
        else if (r < 7)
            e.name[7:0] = BYTE_DELETED;
        else if (r < 10)
            e.name[7:0] = BYTE_KANJI_DEL;
        else if (r < 14)
            e.name[7:0] = BYTE_DOT_ENTRY;
        else if (r < 19)
            e.name = {NAME_BYTES{CH_SPACE}};
        for (i = 0; i < 3; i++)
            e.ext[8*i +: 8] = rand_char();
        if ($urandom_range(0, 99) < 35)
            e.ext[7:0] = CH_SPACE;
        r = $urandom_range(0, 99);
        if (r < 8)
            e.attr = ATTR_LONG;
        else if (r < 25)
            e.attr = ATTR_DIRECTORY | 8'($urandom_range(0, 7));
        else
            e.attr = 8'($urandom_range(0, 255));
        return e;
    endfunction

    task automatic add_row(input logic ns, input logic [63:0] name, input logic [23:0] ext,
                           input logic [7:0] attr, input logic typed, input entry_class_t cls);
        table_row_t row;
        row.entry.new_sector = ns;
        row.entry.name       = name;
        row.entry.ext        = ext;
        row.entry.attr       = attr;
        row.typed            = typed;
        row.cls              = cls;
        directed_rows.push_back(row);
    endtask

    task automatic send_entry(input dir_entry_t e, input logic typed, input entry_class_t cls,
                              input bit quiet);
        display_name_t want;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        new_sector <= e.new_sector;
        name_chars <= e.name;
        ext_chars  <= e.ext;
        attributes <= e.attr;
        @(posedge clk);
        while (full)
            @(posedge clk);
        want = decode_entry(e);
        if (typed)
        begin
            want = '0;
            want.cls = cls;
        end
        expected_names.push_back(want);
    endtask

    task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            errors++;
        end
    endtask

    task automatic check_name();
        display_name_t want;
        if (expected_names.size() == 0)
        begin
            $display("%0t: result with nothing expected: class %0d, length %0d",
                     $time, entry_class, text_length);
            errors++;
            return;
        end
        want = expected_names.pop_front();
        report("entry_class", 64'(want.cls), 64'(entry_class));
        report("is_directory", 64'(want.dir), 64'(is_directory));
        report("text_low", want.lo, text_low);
        report("text_high", 64'(want.hi), 64'(text_high));
        report("text_length", 64'(want.len), 64'(text_length));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Pop side: random idling, one long hold-off so full rises, and a stretch with no idling.
    initial
    begin : drain
        int  hold_left;
        bit  held;
        hold_left = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                check_name();
                names_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (!held && names_seen == HOLD_AT)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end
            else
                pop <= (names_seen >= STEADY_FROM && names_seen < STEADY_TO)
                       || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    initial
    begin : feed
        int n;
        @(posedge rst_n);
        @(posedge clk);

        add_row(1'b1, le8("README  "), 24'h545854, 8'h20, 1'b0, CLS_LISTED);
        add_row(1'b0, 64'h0, 24'h0, 8'h00, 1'b1, CLS_END);
        add_row(1'b0, le8("LATER   "), 24'h545854, 8'h00, 1'b1, CLS_AFTER);
        add_row(1'b0, 64'h0, 24'h0, 8'h00, 1'b1, CLS_AFTER);
        add_row(1'b1, lead_byte(BYTE_DELETED, le8("XOLDFILE")), 24'h544144, 8'h00,
                1'b1, CLS_DELETED);
        add_row(1'b0, lead_byte(BYTE_KANJI_DEL, le8("XKANJI  ")), 24'h202020, 8'h00,
                1'b1, CLS_DELETED);
        add_row(1'b0, le8("LONGNAME"), 24'hFFFFFF, ATTR_LONG, 1'b1, CLS_LONGNAME);
        add_row(1'b0, le8(".       "), 24'h202020, ATTR_DIRECTORY, 1'b1, CLS_DOT);
        add_row(1'b0, le8("..      "), 24'h202020, ATTR_DIRECTORY, 1'b1, CLS_DOT);
        // deleted wins over long name, long name wins over dot
        add_row(1'b0, lead_byte(BYTE_DELETED, le8("XLFN    ")), 24'h202020, ATTR_LONG,
                1'b1, CLS_DELETED);
        add_row(1'b0, le8(".       "), 24'h202020, ATTR_LONG, 1'b1, CLS_LONGNAME);
        // all-space base, with and without extension
        add_row(1'b0, le8("        "), 24'h434241, 8'h00, 1'b0, CLS_LISTED);
        add_row(1'b0, le8("        "), 24'h202020, 8'h00, 1'b1, CLS_LISTED);
        add_row(1'b0, {8{8'hFF}}, 24'hFFFFFF, 8'hFF, 1'b0, CLS_LISTED);
        add_row(1'b0, le8("  A B   "), 24'h595820, 8'h00, 1'b0, CLS_LISTED);
        add_row(1'b0, 64'h20202042_00000041, 24'h000000, 8'h00, 1'b0, CLS_LISTED);
        add_row(1'b0, le8("DIR     "), 24'h202041, ATTR_DIRECTORY, 1'b0, CLS_LISTED);
        add_row(1'b0, le8("ABCDEFGH"), 24'h202020, 8'h00, 1'b0, CLS_LISTED);
        add_row(1'b0, le8("   X    "), 24'h000000, 8'h00, 1'b0, CLS_LISTED);
        add_row(1'b1, 64'h0, 24'h0, 8'h00, 1'b1, CLS_END);
        add_row(1'b1, 64'h0, 24'hFFFFFF, 8'hFF, 1'b1, CLS_END);
        add_row(1'b1, le8("NEXT    "), 24'h474643, 8'h01, 1'b0, CLS_LISTED);

        foreach (directed_rows[i])
            send_entry(directed_rows[i].entry, directed_rows[i].typed, directed_rows[i].cls,
                       1'b0);

        for (n = 0; n < RANDOM_ENTRIES; n++)
            send_entry(random_entry(), 1'b0, CLS_LISTED, n >= STEADY_FROM && n < STEADY_TO);
        push <= 1'b0;

        while (expected_names.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("PASS fat_dir_entry_name_decoder");
        else
            $display("FAIL fat_dir_entry_name_decoder");
        $finish;
    end

endmodule
